### rtl/rah_pkg.sv
// shared types, codes and fixed-point helpers for the range autoscale unit
package rah_pkg;

	localparam int NumSteps  = 4;
	localparam int ValW      = 24;
	localparam int IdxW      = 2;
	localparam int ProdW     = ValW + 4;
	localparam int RecipW    = 32;
	localparam int RecipSh   = 35;

	// ceil(2^35 / 10), exact quotient for any dividend below 2^32
	localparam logic [RecipW-1:0] Recip10 = 32'hCCCC_CCCD;

	localparam logic [IdxW-1:0] IdxFirst = 2'd0;
	localparam logic [IdxW-1:0] IdxLast  = 2'd3;

	// tenths selector for the shared divide unit
	localparam logic [1:0] TenthsUp   = 2'd0;
	localparam logic [1:0] TenthsDown = 2'd1;
	localparam logic [1:0] TenthsSeed = 2'd2;

	// what the compare step does with the threshold
	localparam logic [1:0] ModeUp   = 2'd0;
	localparam logic [1:0] ModeDown = 2'd1;
	localparam logic [1:0] ModeSeed = 2'd2;

	// function codes
	localparam logic FuncUpdate = 1'b0;
	localparam logic FuncReinit = 1'b1;

	typedef logic [ValW-1:0] val_t;
	typedef logic [IdxW-1:0] idx_t;

	typedef struct packed {
		logic func;
		val_t range_value;
		logic range_valid;
		val_t forced_max;
		logic forced_valid;
	} rah_in_t;

	typedef struct packed {
		val_t scale_max;
		idx_t scale_index;
	} rah_out_t;

	// step value times 9, 6 or 8 by shift and add
	function automatic logic [ProdW-1:0] times_tenths(input val_t s, input logic [1:0] sel);
		logic [ProdW-1:0] w;
		logic [ProdW-1:0] p;
		w = {4'd0, s};
		case (sel)
			TenthsUp:   p = (w << 3) + w;
			TenthsDown: p = (w << 2) + (w << 1);
			TenthsSeed: p = w << 3;
			default:    p = '0;
		endcase
		return p;
	endfunction

	// floor(x / 10) by reciprocal multiply
	function automatic val_t div10(input logic [ProdW-1:0] x);
		logic [ProdW+RecipW-1:0] p;
		p = {{RecipW{1'b0}}, x} * {{ProdW{1'b0}}, Recip10};
		return p[RecipSh+ValW-1:RecipSh];
	endfunction

endpackage

### rtl/range_autoscale_hysteresis_unit.sv
// top level: autorange step selection with hysteresis over four scale steps
// a reinitialize without a forced match, a first update or an invalid update goes from
//   idle straight to the output state; a forced-step seed passes DIV and CMP once; an
//   update passes DIV and CMP once per threshold checked, up to 3 checks, each threshold
//   going through the times-tenths / divide-by-10 unit. a new request is taken only in
//   idle, after the previous response is registered. reset restores the default steps
//   and clears the step index, previous range and initialized flag at once.
module range_autoscale_hysteresis_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  rah_pkg::rah_in_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rah_pkg::rah_out_t  rsp,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import rah_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]       state_q;
	val_t             step_q [NumSteps];
	idx_t             idx_q;
	val_t             prev_q;
	logic             init_q;
	val_t             r_q;
	logic [1:0]       mode_q;
	logic [ProdW-1:0] x_q;
	val_t             th_q;
	rah_out_t         rsp_q;
	logic             rsp_valid_q;

	logic accept;
	idx_t fit_idx;
	logic match_hit;
	idx_t match_idx;
	logic up_hit;
	logic dn_hit;
	idx_t nidx;
	logic out_free;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// first step at least the range, last step if none fits
	always_comb begin
		if (req.range_value <= step_q[0]) begin
			fit_idx = 2'd0;
		end else if (req.range_value <= step_q[1]) begin
			fit_idx = 2'd1;
		end else if (req.range_value <= step_q[2]) begin
			fit_idx = 2'd2;
		end else begin
			fit_idx = 2'd3;
		end
	end

	// first step equal to the forced maximum
	always_comb begin
		match_hit = 1'b1;
		if (step_q[0] == req.forced_max) begin
			match_idx = 2'd0;
		end else if (step_q[1] == req.forced_max) begin
			match_idx = 2'd1;
		end else if (step_q[2] == req.forced_max) begin
			match_idx = 2'd2;
		end else if (step_q[3] == req.forced_max) begin
			match_idx = 2'd3;
		end else begin
			match_idx = 2'd0;
			match_hit = 1'b0;
		end
	end

	assign up_hit = (prev_q <= th_q) && (r_q > th_q);
	assign dn_hit = (prev_q >= th_q) && (r_q < th_q);
	assign nidx   = (mode_q == ModeUp) ? idx_q + 2'd1 : idx_q - 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q[0]   <= 24'd2560;
			step_q[1]   <= 24'd5120;
			step_q[2]   <= 24'd10240;
			step_q[3]   <= 24'd20480;
			idx_q       <= '0;
			prev_q      <= '0;
			init_q      <= 1'b0;
			mode_q      <= ModeUp;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q[cfg_index] <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready && state_q != ST_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						r_q <= req.range_value;
						if (req.func == FuncReinit) begin
							init_q <= 1'b1;
							if (req.forced_valid && match_hit) begin
								idx_q <= match_idx;
								if (req.range_valid) begin
									x_q     <= times_tenths(step_q[match_idx], TenthsSeed);
									mode_q  <= ModeSeed;
									state_q <= ST_DIV;
								end else begin
									prev_q  <= '0;
									state_q <= ST_OUT;
								end
							end else begin
								idx_q   <= req.range_valid ? fit_idx : IdxFirst;
								prev_q  <= req.range_valid ? req.range_value : '0;
								state_q <= ST_OUT;
							end
						end else if (req.range_valid) begin
							if (!init_q) begin
								init_q  <= 1'b1;
								idx_q   <= fit_idx;
								prev_q  <= req.range_value;
								state_q <= ST_OUT;
							end else if (req.range_value > prev_q && idx_q != IdxLast) begin
								x_q     <= times_tenths(step_q[idx_q], TenthsUp);
								mode_q  <= ModeUp;
								state_q <= ST_DIV;
							end else if (req.range_value < prev_q && idx_q != IdxFirst) begin
								x_q     <= times_tenths(step_q[idx_q], TenthsDown);
								mode_q  <= ModeDown;
								state_q <= ST_DIV;
							end else begin
								prev_q  <= req.range_value;
								state_q <= ST_OUT;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					th_q    <= div10(x_q);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					case (mode_q)
						ModeSeed: begin
							prev_q  <= (r_q < th_q) ? r_q : th_q;
							state_q <= ST_OUT;
						end
						// previous range stays put until the cascade ends
						ModeUp: begin
							if (up_hit && nidx != IdxLast) begin
								idx_q   <= nidx;
								x_q     <= times_tenths(step_q[nidx], TenthsUp);
								state_q <= ST_DIV;
							end else begin
								if (up_hit) begin
									idx_q <= nidx;
								end
								prev_q  <= r_q;
								state_q <= ST_OUT;
							end
						end
						ModeDown: begin
							if (dn_hit && nidx != IdxFirst) begin
								idx_q   <= nidx;
								x_q     <= times_tenths(step_q[nidx], TenthsDown);
								state_q <= ST_DIV;
							end else begin
								if (dn_hit) begin
									idx_q <= nidx;
								end
								prev_q  <= r_q;
								state_q <= ST_OUT;
							end
						end
						default: begin
							prev_q  <= r_q;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (out_free) begin
						rsp_q.scale_max   <= step_q[idx_q];
						rsp_q.scale_index <= idx_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("request accepted while previous one still in work");

	a_climb_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && mode_q == ModeUp)
		|=> (idx_q == $past(idx_q) || idx_q == $past(idx_q) + 2'd1))
		else $error("upward check moved more than one step");

	a_fall_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && mode_q == ModeDown)
		|=> (idx_q == $past(idx_q) || idx_q == $past(idx_q) - 2'd1))
		else $error("downward check moved more than one step");

	a_rsp_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (rsp_valid && rsp.scale_index == $past(idx_q)))
		else $error("response index differs from selected step");

	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |=> init_q)
		else $error("initialized flag dropped");

endmodule

### sim/range_autoscale_hysteresis_unit_tb.sv
// testbench for the range autoscale unit: directed table, random requests, scoreboard
module range_autoscale_hysteresis_unit_tb;
	import rah_pkg::*;

	localparam int SettleCycles = 12;
	localparam int HoldOff      = 300;
	localparam int StallLimit   = 3000;
	localparam int RandPerPhase = 240;
	localparam int NumPhases    = 6;
	localparam int PrintCap     = 40;

	typedef struct {
		rah_in_t  item;
		bit       typed;
		rah_out_t want;
	} dir_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	rah_in_t  req;
	logic     rsp_valid;
	logic     rsp_ready;
	rah_out_t rsp;
	logic     cfg_we;
	idx_t     cfg_index;
	val_t     cfg_data;

	// predictor state
	val_t step_max [NumSteps];
	idx_t sel_idx;
	val_t last_range;
	bit   scale_ready;

	rah_out_t scale_q [$];
	dir_row_t dir_rows [$];
	rah_out_t head_exp;
	int       n_req;
	int       n_rsp;
	int       n_err;
	int       idle_cycles;
	bit       calm;
	bit       hold_rsp;

	range_autoscale_hysteresis_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic val_t tenths(input val_t v, input int t);
		return val_t'((longint'(v) * t) / 10);
	endfunction

	// advances the step selection by one request and returns the scale it reports
	function automatic rah_out_t predict_scale(input rah_in_t it);
		rah_out_t res;
		val_t     prev;
		val_t     th;
		val_t     seed;
		bit       moving;
		bit       hit;
		hit = 1'b0;
		if (it.func == FuncReinit || (it.range_valid && !scale_ready)) begin
			scale_ready = 1'b1;
			if (it.func == FuncReinit && it.forced_valid) begin
				for (int k = 0; k < NumSteps; k++) begin
					if (!hit && step_max[k] == it.forced_max) begin
						hit = 1'b1;
						sel_idx = idx_t'(k);
						seed = tenths(step_max[k], 8);
						if (!it.range_valid)
							last_range = '0;
						else
							last_range = (it.range_value < seed) ? it.range_value : seed;
					end
				end
			end
			if (!hit) begin
				sel_idx = IdxLast;
				if (it.range_valid) begin
					// first step that holds the range, largest if none does
					for (int k = NumSteps - 1; k >= 0; k--)
						if (it.range_value <= step_max[k])
							sel_idx = idx_t'(k);
				end else begin
					sel_idx = IdxFirst;
				end
				last_range = it.range_valid ? it.range_value : '0;
			end
		end else if (it.range_valid) begin
			prev = last_range;
			moving = 1'b1;
			if (it.range_value > prev) begin
				repeat (NumSteps - 1) begin
					if (moving && sel_idx != IdxLast) begin
						th = tenths(step_max[sel_idx], 9);
						if (prev <= th && it.range_value > th)
							sel_idx++;
						else
							moving = 1'b0;
					end
				end
			end else if (it.range_value < prev) begin
				repeat (NumSteps - 1) begin
					if (moving && sel_idx != IdxFirst) begin
						th = tenths(step_max[sel_idx], 6);
						if (prev >= th && it.range_value < th)
							sel_idx--;
						else
							moving = 1'b0;
					end
				end
			end
			last_range = it.range_value;
		end
		res.scale_max = step_max[sel_idx];
		res.scale_index = sel_idx;
		return res;
	endfunction

	// ranges cluster around the hysteresis thresholds and the last range
	function automatic val_t pick_range();
		longint base;
		longint top;
		top = 1;
		for (int k = 0; k < NumSteps; k++)
			if (step_max[k] > top)
				top = longint'(step_max[k]);
		case ($urandom_range(0, 9))
			0: return val_t'($urandom());
			1: return '0;
			2: return '1;
			3, 4, 5: begin
				base = longint'(step_max[idx_t'($urandom_range(0, NumSteps - 1))]);
				case ($urandom_range(0, 3))
					0: base = base * 9 / 10;
					1: base = base * 6 / 10;
					2: base = base * 8 / 10;
					default: ;
				endcase
				base = base + int'($urandom_range(0, 4)) - 2;
			end
			6: base = longint'(last_range) + int'($urandom_range(0, 6)) - 3;
			default: base = longint'($urandom_range(0, int'(top)));
		endcase
		if (base < 0)
			base = 0;
		if (base > 64'hFF_FFFF)
			base = 64'hFF_FFFF;
		return val_t'(base);
	endfunction

	task automatic add_row(input logic fn, input val_t r, input logic rv, input val_t f,
			input logic fv, input bit typed, input val_t smax, input idx_t sidx);
		dir_row_t row;
		row.item.func = fn;
		row.item.range_value = r;
		row.item.range_valid = rv;
		row.item.forced_max = f;
		row.item.forced_valid = fv;
		row.typed = typed;
		row.want.scale_max = smax;
		row.want.scale_index = sidx;
		dir_rows.push_back(row);
	endtask

	task automatic offer(input rah_in_t it, input bit typed, input rah_out_t want);
		rah_out_t pred;
		int       gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pred = predict_scale(it);
		scale_q.push_back(typed ? want : pred);
		n_req++;
	endtask

	task automatic wait_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (scale_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_steps(input val_t s0, input val_t s1, input val_t s2, input val_t s3);
		val_t v [NumSteps];
		v = '{s0, s1, s2, s3};
		wait_results();
		repeat (SettleCycles) @(posedge clk);
		for (int k = 0; k < NumSteps; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx_t'(k);
			cfg_data <= v[k];
			@(posedge clk);
			step_max[k] = v[k];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (n_err < PrintCap)
			$display("mismatch on %s at result %0d: got %0d, expected %0d",
				what, n_rsp, got, want);
		n_err++;
	endtask

	// response side: ready bursts, one long hold-off on request
	initial begin : rsp_side
		int n;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HoldOff) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				n = $urandom_range(1, 14);
				repeat (n) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end
		end
	end

	// scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (scale_q.size() == 0) begin
					flag_mismatch("result with none pending", rsp.scale_index, -1);
				end else begin
					head_exp = scale_q.pop_front();
					if (rsp.scale_max !== head_exp.scale_max)
						flag_mismatch("scale_max", rsp.scale_max, head_exp.scale_max);
					if (rsp.scale_index !== head_exp.scale_index)
						flag_mismatch("scale_index", rsp.scale_index, head_exp.scale_index);
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("timeout: no handshake for %0d cycles, %0d results pending",
					StallLimit, scale_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		rah_in_t  it;
		rah_out_t none;
		val_t     a;
		val_t     b;
		val_t     c;
		none = '0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		n_req = 0;
		n_rsp = 0;
		n_err = 0;
		idle_cycles = 0;
		step_max = '{24'd2560, 24'd5120, 24'd10240, 24'd20480};
		sel_idx = IdxFirst;
		last_range = '0;
		scale_ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// invalid update before the first valid one
		add_row(FuncUpdate, 24'd0, 1'b0, 24'd0, 1'b0, 1, 24'd2560, 2'd0);
		// first valid update initializes the scale
		add_row(FuncUpdate, 24'd3000, 1'b1, 24'd0, 1'b0, 1, 24'd5120, 2'd1);
		// full cascades up and down
		add_row(FuncUpdate, 24'hFF_FFFF, 1'b1, 24'd0, 1'b0, 1, 24'd20480, 2'd3);
		add_row(FuncUpdate, 24'd0, 1'b1, 24'd0, 1'b0, 1, 24'd2560, 2'd0);
		// equal range keeps the step
		add_row(FuncUpdate, 24'd0, 1'b1, 24'd0, 1'b0, 1, 24'd2560, 2'd0);
		add_row(FuncUpdate, 24'd4700, 1'b1, 24'd0, 1'b0, 0, '0, '0);
		add_row(FuncUpdate, 24'd4000, 1'b1, 24'd0, 1'b0, 0, '0, '0);
		add_row(FuncReinit, 24'd0, 1'b1, 24'd0, 1'b0, 1, 24'd2560, 2'd0);
		add_row(FuncReinit, 24'hFF_FFFF, 1'b1, 24'd0, 1'b0, 1, 24'd20480, 2'd3);
		// forced step that matches nothing
		add_row(FuncReinit, 24'd2561, 1'b1, 24'd5121, 1'b1, 1, 24'd5120, 2'd1);
		// invalid range on reinit, with and without a forced step
		add_row(FuncReinit, 24'd0, 1'b0, 24'd10240, 1'b1, 1, 24'd10240, 2'd2);
		add_row(FuncReinit, 24'd0, 1'b0, 24'd0, 1'b0, 1, 24'd2560, 2'd0);
		// forced step seeds the previous range with 8/10 of the step
		add_row(FuncReinit, 24'hFF_FFFF, 1'b1, 24'd5120, 1'b1, 1, 24'd5120, 2'd1);
		add_row(FuncUpdate, 24'd4097, 1'b1, 24'd0, 1'b0, 0, '0, '0);
		// matching forced value but not flagged as supplied
		add_row(FuncReinit, 24'd100, 1'b1, 24'd20480, 1'b0, 1, 24'd2560, 2'd0);
		add_row(FuncReinit, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b1, 1, 24'd20480, 2'd3);
		add_row(FuncUpdate, 24'hFF_FFFF, 1'b0, 24'hFF_FFFF, 1'b1, 1, 24'd20480, 2'd3);
		add_row(FuncReinit, 24'd5120, 1'b1, 24'd20480, 1'b1, 1, 24'd20480, 2'd3);
		add_row(FuncUpdate, 24'd12287, 1'b1, 24'd0, 1'b0, 0, '0, '0);
		add_row(FuncReinit, 24'd10240, 1'b1, 24'd10240, 1'b1, 1, 24'd10240, 2'd2);
		add_row(FuncUpdate, 24'd5000, 1'b1, 24'd0, 1'b0, 0, '0, '0);
		foreach (dir_rows[k])
			offer(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: begin
					a = val_t'($urandom_range(1, 5000));
					b = a + val_t'($urandom_range(1, 20000));
					c = b + val_t'($urandom_range(1, 200000));
					load_steps(a, b, c, c + val_t'($urandom_range(1, 16000000)));
				end
				1: load_steps(24'd1, 24'd2, 24'hFF_FFFE, 24'hFF_FFFF);
				2: load_steps(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
				3: load_steps(val_t'($urandom_range(5000, 20000)), 24'd0,
					val_t'($urandom_range(1, 3000)), val_t'($urandom_range(100000, 16777215)));
				4: load_steps(24'd300, 24'd300, 24'd7000, 24'd7000);
				default: load_steps(24'd2560, 24'd5120, 24'd10240, 24'd20480);
			endcase
			calm = (p == NumPhases - 1);
			for (int n = 0; n < RandPerPhase; n++) begin
				// the block backs up behind a stalled receiver
				if (p == 0 && n == 40)
					hold_rsp = 1'b1;
				if (p == 0 && n == 150)
					wait_results();
				it.func = ($urandom_range(0, 4) == 0) ? FuncReinit : FuncUpdate;
				it.range_value = pick_range();
				it.range_valid = ($urandom_range(0, 9) != 0);
				it.forced_valid = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 2) != 0)
					it.forced_max = step_max[idx_t'($urandom_range(0, NumSteps - 1))];
				else
					it.forced_max = val_t'($urandom());
				offer(it, 0, none);
			end
		end

		wait_results();
		repeat (SettleCycles) @(posedge clk);
		if (scale_q.size() != 0)
			flag_mismatch("results never delivered", 0, scale_q.size());
		$display("%0d requests, %0d results checked over %0d step settings, %0d mismatches",
			n_req, n_rsp, NumPhases + 1, n_err);
		$display("covered cascades both ways, forced and unforced reinit, invalid ranges");
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
